// ===== rtl/core/tsk_pkg.sv =====
`default_nettype none

package tsk_pkg;

  // field widths
  localparam int unsigned DayW  = 32;
  localparam int unsigned SodW  = 17;
  localparam int unsigned FracW = 32;
  localparam int unsigned AmtW  = 41;
  localparam int unsigned TotW  = 49;

  // shared multiplier: signed A times unsigned B
  localparam int unsigned MulAW = 36;
  localparam int unsigned MulBW = 32;
  localparam int unsigned MulPW = MulAW + MulBW;

  localparam logic [SodW-1:0] SecsPerDay = 17'd86400;

  // fraction units per ms, us and ns
  localparam logic [MulBW-1:0] ScaleMs = 32'd4294967;
  localparam logic [MulBW-1:0] ScaleUs = 32'd4295;
  localparam logic [MulBW-1:0] ScaleNs = 32'd4;

  // 86400 = 675 * 2^7: shift off seven bits, then divide by 675
  localparam int unsigned LoShift = 7;
  localparam int unsigned Div675  = 675;

  // offset that makes the quotient input non-negative, a multiple of 675
  localparam int unsigned DivOffW   = 24;
  localparam logic [35:0] DivOffset = 36'(Div675) << DivOffW;
  localparam logic [26:0] QuBias    = 27'd1 << DivOffW;

  // reciprocal of 675, exact for dividends below 2^35
  localparam int unsigned RecipShift = 45;
  localparam logic [63:0] Recip =
    ((64'd1 << RecipShift) + 64'(Div675) - 64'd1) / 64'(Div675);
  localparam logic [MulBW-1:0] RecipLo = Recip[31:0];
  localparam logic [MulBW-1:0] RecipHi = {28'd0, Recip[35:32]};

  // rounding of the fraction to decimal units
  localparam logic [FracW-1:0] MsBias = 32'd2147483;
  localparam logic [FracW-1:0] UsBias = 32'd2147;
  localparam logic [FracW-1:0] NsBias = 32'd2;
  localparam logic [FracW-1:0] MsSat  = 32'd4290000000;
  localparam logic [FracW-1:0] UsSat  = 32'd4294963000;
  localparam logic [FracW-1:0] NsSat  = 32'd4294967290;
  localparam logic [MulBW-1:0] MsMul  = 32'd1000;
  localparam logic [MulBW-1:0] UsMul  = 32'd1000000;
  localparam logic [MulBW-1:0] NsMul  = 32'd1000000000;
  localparam logic [9:0]       MsMax  = 10'd999;
  localparam logic [19:0]      UsMax  = 20'd999999;
  localparam logic [29:0]      NsMax  = 30'd999999999;

  typedef enum logic [2:0] {
    MODE_ADD_S     = 3'd0,
    MODE_ADD_MS    = 3'd1,
    MODE_ADD_US    = 3'd2,
    MODE_ADD_NS    = 3'd3,
    MODE_SET_EPOCH = 3'd4,
    MODE_SET_DAYS  = 3'd5,
    MODE_SET_FRAC  = 3'd6,
    MODE_READ      = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC_LO,
    ST_SC_HI,
    ST_SC_ADD,
    ST_DV_OFF,
    ST_DV_LO,
    ST_DV_HI,
    ST_DV_Q,
    ST_DV_R,
    ST_DV_S,
    ST_TOT,
    ST_MS,
    ST_US,
    ST_NS,
    ST_FIN
  } st_t;

  typedef struct packed {
    st_t  step;
    logic in_ready;
    logic out_load;
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/tsk_mul.sv =====
`default_nettype none

module tsk_mul (
  input  logic                              clk,
  input  logic signed [tsk_pkg::MulAW-1:0] a,
  input  logic        [tsk_pkg::MulBW-1:0] b,
  output logic signed [tsk_pkg::MulPW-1:0] prod
);
  import tsk_pkg::*;

  logic signed [MulPW:0] full;

  // signed by unsigned product, one per cycle
  assign full = a * $signed({1'b0, b});

  // register the product
  always_ff @(posedge clk) begin
    prod <= full[MulPW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsk_seq.sv =====
`default_nettype none

module tsk_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  tsk_pkg::mode_t mode,
  input  logic           out_free,
  output tsk_pkg::ctl_t  ctl
);
  import tsk_pkg::*;

  st_t state, state_next;

  // hold the step register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // advance through the steps of one command
  always_comb begin
    state_next   = state;
    ctl.step     = state;
    ctl.in_ready = (state == ST_IDLE);
    ctl.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            MODE_ADD_S, MODE_SET_EPOCH:            state_next = ST_DV_OFF;
            MODE_ADD_MS, MODE_ADD_US, MODE_ADD_NS: state_next = ST_SC_LO;
            default:                               state_next = ST_TOT;
          endcase
        end
      end
      ST_SC_LO:  state_next = ST_SC_HI;
      ST_SC_HI:  state_next = ST_SC_ADD;
      ST_SC_ADD: state_next = ST_DV_OFF;
      ST_DV_OFF: state_next = ST_DV_LO;
      ST_DV_LO:  state_next = ST_DV_HI;
      ST_DV_HI:  state_next = ST_DV_Q;
      ST_DV_Q:   state_next = ST_DV_R;
      ST_DV_R:   state_next = ST_DV_S;
      ST_DV_S:   state_next = ST_TOT;
      ST_TOT:    state_next = ST_MS;
      ST_MS:     state_next = ST_US;
      ST_US:     state_next = ST_NS;
      ST_NS:     state_next = ST_FIN;
      ST_FIN: begin
        ctl.out_load = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/timestamp_keeper.sv =====
`default_nettype none

// channel  signals                                        transfer when
// -------  ---------------------------------------------  ----------------------
// in       in_valid, in_ready, mode, amount               in_valid && in_ready
// out      out_valid, out_ready, day_value to nanos       out_valid && out_ready
//
// One command at a time through a single 36x32 multiplier under a sequencer.
// ms/us/ns advances pass through scaling, the divide and the output steps;
// second advances and epoch sets skip scaling; set days, set fraction and read
// run only the output steps. The multiplier steps are scaling, the reciprocal
// divide by 675 and four output products. Reset clears the timestamp to zero.
// A result waiting in the output register holds the sequencer in its last step.

module timestamp_keeper (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         mode,
  input  logic signed [tsk_pkg::AmtW-1:0]    amount,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tsk_pkg::DayW-1:0]    day_value,
  output logic [tsk_pkg::SodW-1:0]           second_value,
  output logic [tsk_pkg::FracW-1:0]          fraction_value,
  output logic signed [tsk_pkg::TotW-1:0]    total_seconds,
  output logic [9:0]                         millis,
  output logic [19:0]                        micros,
  output logic [29:0]                        nanos
);
  import tsk_pkg::*;

  ctl_t  ctl;
  mode_t in_mode;
  logic  accept;
  logic  out_free;

  // timestamp state
  logic [DayW-1:0]  day;
  logic [SodW-1:0]  sod;
  logic [FracW-1:0] sub;

  // working registers
  mode_t               mode_q;
  logic [AmtW-1:0]     amt;
  logic [55:0]         tsum;
  logic [41:0]         x;
  logic [34:0]         u;
  logic [LoShift-1:0]  rlo;
  logic [34:0]         accq;
  logic [25:0]         qu;
  logic [TotW-1:0]     tot;
  logic [9:0]          ms;
  logic [19:0]         us;

  // multiplier
  logic signed [MulAW-1:0] mul_a;
  logic [MulBW-1:0]        mul_b;
  logic signed [MulPW-1:0] prod;
  logic [MulBW-1:0]        scale;

  // combinational helpers
  logic [33:0] secs;
  logic [35:0] uoff;
  logic [39:0] qsum;
  logic [26:0] dq;
  logic [34:0] rem;
  logic [29:0] ns_val;

  assign in_mode  = mode_t'(mode);
  assign in_ready = ctl.in_ready;
  assign accept   = in_valid && ctl.in_ready;
  assign out_free = !out_valid || out_ready;

  tsk_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (in_mode),
    .out_free (out_free),
    .ctl      (ctl)
  );

  tsk_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // pick the scale of a sub-second advance
  always_comb begin
    unique case (mode_q)
      MODE_ADD_MS: scale = ScaleMs;
      MODE_ADD_US: scale = ScaleUs;
      default:     scale = ScaleNs;
    endcase
  end

  // steer multiplier operands for each step
  always_comb begin
    unique case (ctl.step)
      ST_SC_LO: begin
        mul_a = {4'd0, amt[31:0]};
        mul_b = scale;
      end
      ST_SC_HI: begin
        mul_a = {{27{amt[AmtW-1]}}, amt[AmtW-1:32]};
        mul_b = scale;
      end
      ST_DV_LO: begin
        mul_a = {1'b0, u};
        mul_b = RecipLo;
      end
      ST_DV_HI: begin
        mul_a = {1'b0, u};
        mul_b = RecipHi;
      end
      ST_DV_R: begin
        mul_a = {10'd0, qu};
        mul_b = 32'(Div675);
      end
      ST_TOT: begin
        mul_a = {{4{day[DayW-1]}}, day};
        mul_b = 32'(SecsPerDay);
      end
      ST_MS: begin
        mul_a = {4'd0, sub + MsBias};
        mul_b = MsMul;
      end
      ST_US: begin
        mul_a = {4'd0, sub + UsBias};
        mul_b = UsMul;
      end
      default: begin
        mul_a = {4'd0, sub + NsBias};
        mul_b = NsMul;
      end
    endcase
  end

  // carry of the fraction into seconds: high product plus carry of low sum
  assign secs = {prod[32], prod[32:0]} + {10'd0, tsum[55:32]};
  // floor of x / 128, shifted up by a multiple of 675
  assign uoff = {x[41], x[41:LoShift]} + DivOffset;
  // quotient from the two reciprocal partial products
  assign qsum = {5'd0, accq} + prod[39:0];
  // day delta with the offset taken back out
  assign dq   = {1'b0, qu} - QuBias;
  // remainder of the divide by 675
  assign rem  = u - prod[34:0];
  assign ns_val = (sub >= NsSat) ? NsMax : prod[61:32];

  // update the timestamp and the result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      day       <= '0;
      sod       <= '0;
      sub       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept && in_mode == MODE_SET_DAYS) begin
        day <= amount[DayW-1:0];
      end
      if (accept && in_mode == MODE_SET_FRAC) begin
        sub <= amount[FracW-1:0];
      end
      if (ctl.step == ST_SC_ADD) begin
        sub <= tsum[31:0];
      end
      if (ctl.step == ST_DV_R) begin
        if (mode_q == MODE_SET_EPOCH) begin
          day <= {{5{dq[26]}}, dq};
        end else begin
          day <= day + {{5{dq[26]}}, dq};
        end
      end
      if (ctl.step == ST_DV_S) begin
        sod <= {rem[9:0], rlo};
        if (mode_q == MODE_SET_EPOCH) begin
          sub <= '0;
        end
      end
    end
  end

  // working registers of the sequence
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= in_mode;
      amt    <= amount;
      if (in_mode == MODE_SET_EPOCH) begin
        x <= {amount[AmtW-1], amount};
      end else begin
        x <= {25'd0, sod} + {amount[AmtW-1], amount};
      end
    end
    unique case (ctl.step)
      ST_SC_HI:  tsum <= {1'b0, prod[54:0]} + {24'd0, sub};
      ST_SC_ADD: x    <= {25'd0, sod} + {{8{secs[33]}}, secs};
      ST_DV_OFF: begin
        u   <= uoff[34:0];
        rlo <= x[LoShift-1:0];
      end
      ST_DV_HI:  accq <= prod[66:32];
      ST_DV_Q:   qu   <= qsum[38:13];
      ST_MS:     tot  <= prod[TotW-1:0] + {32'd0, sod};
      ST_US:     ms   <= (sub >= MsSat) ? MsMax : prod[41:32];
      ST_NS:     us   <= (sub >= UsSat) ? UsMax : prod[51:32];
      default: begin
      end
    endcase
  end

  // load the output register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      day_value      <= day;
      second_value   <= sod;
      fraction_value <= sub;
      total_seconds  <= tot;
      millis         <= ms;
      micros         <= us;
      nanos          <= ns_val;
    end
  end

  // second of day stays within one day
  a_sod_range: assert property (@(posedge clk) disable iff (rst)
    sod < SecsPerDay)
    else $error("second of day out of range");

  // reciprocal divide leaves a proper remainder
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.step == ST_DV_S) |-> (rem < 35'(Div675)))
    else $error("divide by 675 remainder out of range");

  // a load always presents a result next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> out_valid)
    else $error("loaded result not presented");

  // rounded conversions stay saturated
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (millis <= MsMax && micros <= UsMax && nanos <= NsMax))
    else $error("rounded fraction out of range");

endmodule

`default_nettype wire
